FILE: hdl/itrt_pkg.sv
// ----------------------------------------------------------------------------
// itrt_pkg: shared types and constants for the integer to radix text core
// Widths, character codes, radix limits and the digit to ASCII mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package itrt_pkg;

    // Sizing
    localparam int VALUE_WIDTH = 64;
    localparam int MAX_DIGITS  = 64;
    localparam int RESULT_CAP  = 64;

    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 8;
    localparam int ADDR_W  = $clog2(MAX_DIGITS);
    localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
    localparam int BIT_W   = $clog2(VALUE_WIDTH);

    // Digit limits with and without a leading minus sign
    localparam int CAP_POS = (MAX_DIGITS < RESULT_CAP) ? MAX_DIGITS : RESULT_CAP;
    localparam int CAP_NEG = (MAX_DIGITS < RESULT_CAP - 1) ? MAX_DIGITS : RESULT_CAP - 1;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LETTER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_MINUS    = 8'h2D;

    // Radix limits
    localparam logic [RADIX_W-1:0] DECIMAL   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    // Request to the shared divider
    typedef struct packed {
        logic                   start;
        logic [VALUE_WIDTH-1:0] dividend;
        logic [RADIX_W-1:0]     divisor;
    } div_ctrl_t;

    // Status and result from the shared divider
    typedef struct packed {
        logic                   busy;
        logic                   done;
        logic [VALUE_WIDTH-1:0] quotient;
        logic [DIGIT_W-1:0]     remainder;
    } div_stat_t;

    // Map one digit to its ASCII character
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dw;
        dw = {{(CHAR_W - DIGIT_W){1'b0}}, d};
        if (d < DECIMAL)
            return CH_ZERO + dw;
        else
            return CH_LETTER_A + (dw - {{(CHAR_W - RADIX_W){1'b0}}, DECIMAL});
    endfunction

endpackage

`default_nettype wire

FILE: hdl/itrt_ram.sv
// ----------------------------------------------------------------------------
// itrt_ram: generic single write, single read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module itrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/itrt_divider.sv
// ----------------------------------------------------------------------------
// itrt_divider: shared shift-subtract divider by the radix
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module itrt_divider
    import itrt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire div_ctrl_t ctrl,
    output div_stat_t      stat
);

    logic                   busy_reg,  busy_next;
    logic                   done_reg,  done_next;
    logic [BIT_W-1:0]       cnt_reg,   cnt_next;
    logic [VALUE_WIDTH-1:0] quo_reg,   quo_next;
    logic [DIGIT_W-1:0]     rem_reg,   rem_next;
    logic [RADIX_W-1:0]     div_reg,   div_next;

    logic [DIGIT_W:0] trial;
    logic             fits;

    // Shift in the next dividend bit and try one subtract
    assign trial = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (busy_reg)
        begin
            quo_next = {quo_reg[VALUE_WIDTH-2:0], fits};
            rem_next = fits ? DIGIT_W'(trial - {1'b0, div_reg}) : DIGIT_W'(trial);
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = BIT_W'(VALUE_WIDTH - 1);
            quo_next  = ctrl.dividend;
            rem_next  = '0;
            div_next  = ctrl.divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= RADIX_MIN;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            div_reg  <= div_next;
        end
    end

    assign stat.busy      = busy_reg;
    assign stat.done      = done_reg;
    assign stat.quotient  = quo_reg;
    assign stat.remainder = rem_reg;

endmodule

`default_nettype wire

FILE: hdl/integer_to_radix_text_core.sv
// ----------------------------------------------------------------------------
// integer_to_radix_text_core: integer to ASCII text in radix 2 to 36
// Divides repeatedly by the radix, stacks the digits in a small RAM and
// replays them most significant first, with a leading '-' for negative
// decimal values.
// ----------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  in       in_valid / in_ready   number_bits, signed_mode, radix
//  out      out_valid / out_ready out_char, last_char
//
//  Each digit is computed by the shared bit-serial divider. Each digit
//  character then passes the states S_READ (RAM read), S_LOAD and S_SHOW,
//  and S_SHOW waits through any output stall; a minus sign waits in S_SIGN.
//  in_ready is high only when idle; the digit RAM needs no clearing after
//  reset. A stalled output holds its character until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_radix_text_core
    import itrt_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [63:0]            number_bits,
    input  wire logic                   signed_mode,
    input  wire logic [RADIX_W-1:0]     radix,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic      [CHAR_W-1:0]      out_char,
    output logic                        last_char
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_READ,
        S_LOAD,
        S_SHOW
    } state_t;

    state_t             state_reg,  state_next;
    logic [RADIX_W-1:0] base_reg,   base_next;
    logic               neg_reg,    neg_next;
    logic [CNT_W-1:0]   nd_reg,     nd_next;
    logic [ADDR_W-1:0]  ptr_reg,    ptr_next;
    logic               valid_reg,  valid_next;
    logic [CHAR_W-1:0]  char_reg,   char_next;
    logic               last_reg,   last_next;

    logic                   in_take;
    logic                   out_take;
    logic [RADIX_W-1:0]     base_sat;
    logic [VALUE_WIDTH-1:0] value;
    logic                   value_neg;
    logic [VALUE_WIDTH-1:0] magnitude;
    logic [CNT_W-1:0]       cap;
    logic [CNT_W-1:0]       nd_inc;

    div_ctrl_t           div_ctrl;
    div_stat_t           div_stat;
    logic                ram_we;
    logic                ram_re;
    logic [DIGIT_W-1:0]  ram_rdata;

    assign in_take  = in_valid && in_ready;
    assign out_take = valid_reg && out_ready;

    // Saturate the radix and pick sign and magnitude
    always_comb
    begin
        if (radix < RADIX_MIN)
            base_sat = RADIX_MIN;
        else if (radix > RADIX_MAX)
            base_sat = RADIX_MAX;
        else
            base_sat = radix;
    end

    assign value     = number_bits[VALUE_WIDTH-1:0];
    assign value_neg = signed_mode && (base_sat == DECIMAL) && value[VALUE_WIDTH-1];
    assign magnitude = value_neg ? VALUE_WIDTH'(~value + 1'b1) : value;

    // Digit limit for this request
    assign cap    = neg_reg ? CNT_W'(CAP_NEG) : CNT_W'(CAP_POS);
    assign nd_inc = nd_reg + 1'b1;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        neg_next   = neg_reg;
        nd_next    = nd_reg;
        ptr_next   = ptr_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;

        div_ctrl.start    = 1'b0;
        div_ctrl.dividend = div_stat.quotient;
        div_ctrl.divisor  = base_reg;
        ram_we            = 1'b0;
        ram_re            = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    div_ctrl.start    = 1'b1;
                    div_ctrl.dividend = magnitude;
                    div_ctrl.divisor  = base_sat;
                    base_next         = base_sat;
                    neg_next          = value_neg;
                    nd_next           = '0;
                    state_next        = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    // Stack the digit, then divide again or start output
                    ram_we   = 1'b1;
                    nd_next  = nd_inc;
                    ptr_next = nd_reg[ADDR_W-1:0];
                    if ((div_stat.quotient != '0) && (nd_inc < cap))
                    begin
                        div_ctrl.start = 1'b1;
                    end
                    else if (neg_reg)
                    begin
                        valid_next = 1'b1;
                        char_next  = CH_MINUS;
                        last_next  = 1'b0;
                        state_next = S_SIGN;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_SIGN:
            begin
                if (out_take)
                begin
                    valid_next = 1'b0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                valid_next = 1'b1;
                char_next  = digit_to_ascii(ram_rdata);
                last_next  = (ptr_reg == '0);
                state_next = S_SHOW;
            end
            S_SHOW:
            begin
                if (out_take)
                begin
                    valid_next = 1'b0;
                    if (ptr_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg - 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
                valid_next = 1'b0;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            base_reg  <= RADIX_MIN;
            neg_reg   <= 1'b0;
            nd_reg    <= '0;
            ptr_reg   <= '0;
            valid_reg <= 1'b0;
            char_reg  <= CH_ZERO;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            neg_reg   <= neg_next;
            nd_reg    <= nd_next;
            ptr_reg   <= ptr_next;
            valid_reg <= valid_next;
            char_reg  <= char_next;
            last_reg  <= last_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign last_char = last_reg;

    // Shared divider
    itrt_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .stat  (div_stat)
    );

    // Digit stack
    itrt_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_digit_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (nd_reg[ADDR_W-1:0]),
        .wdata (div_stat.remainder),
        .re    (ram_re),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

FILE: hdl/itrt_checker.sv
// ----------------------------------------------------------------------------
// itrt_checker: port-level checks for the integer to radix text core
// Watches both channels and flags sequencing and character slips.
// ----------------------------------------------------------------------------
`default_nettype none

module itrt_checker
    import itrt_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_ready,
    input wire logic [63:0]            number_bits,
    input wire logic                   signed_mode,
    input wire logic [RADIX_W-1:0]     radix,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic [CHAR_W-1:0]      out_char,
    input wire logic                   last_char
);

    // Never take a request while a character is pending
    a_idle_no_output: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("in_ready high while a character is pending");

    // Drop ready right after a request is taken
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready still high after a request");

    // Return to idle after the last character is taken
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_char) |=> (!out_valid && in_ready))
        else $error("block not idle after the last character");

    // Hold a stalled character
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_char) && $stable(last_char)))
        else $error("stalled character changed");

    // Emit only digits, upper-case letters or a minus sign
    a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            ((out_char >= 8'h30 && out_char <= 8'h39) ||
             (out_char >= 8'h41 && out_char <= 8'h5A) ||
             (out_char == CH_MINUS)))
        else $error("illegal character on output");

endmodule

bind integer_to_radix_text_core itrt_checker u_checker (.*);

`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the integer to radix text core
// Sends conversion requests over a valid/ready channel. Bursts of requests
// are separated by random gaps, and the output side stalls on a rotating
// pattern. Each request is predicted into a queue of expected characters.
// Every character that comes out is compared with the oldest one waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import itrt_pkg::*;

    localparam int RANDOM_REQUESTS = 140;
    localparam int DRAIN_EVERY     = 40;
    localparam int IDLE_LIMIT      = 20000;
    localparam int SETTLE_CYCLES   = 300;

    typedef struct {
        logic [63:0]        number_bits;
        logic               signed_mode;
        logic [RADIX_W-1:0] radix;
        bit                 drain_first;
    } text_request_t;

    typedef struct {
        logic [CHAR_W-1:0] out_char;
        logic              last_char;
    } text_char_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [63:0]        number_bits = '0;
    logic               signed_mode = 1'b0;
    logic [RADIX_W-1:0] radix = RADIX_MIN;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [CHAR_W-1:0]  out_char;
    logic               last_char;

    text_request_t pending_requests[$];
    text_char_t    expected_chars[$];
    int            fail_count = 0;
    int            idle_cycles = 0;
    int            gap_left = 0;
    int            burst_left = 0;
    logic [15:0]   stall_pattern = 16'hFFFF;
    int            stall_age = 0;

    integer_to_radix_text_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .number_bits (number_bits),
        .signed_mode (signed_mode),
        .radix       (radix),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .last_char   (last_char)
    );

    always #6 clk = ~clk;

    // Work out the characters of one request and queue them
    function automatic void predict_text(input logic [63:0] value, input logic sgn,
                                         input logic [RADIX_W-1:0] rdx);
        logic [63:0] mask;
        logic [63:0] v;
        logic [63:0] base;
        logic [63:0] digit_stack[$];
        logic [63:0] d;
        logic [7:0]  ch;
        logic        neg;
        int          cap;
        int          total;
        int          k;
        mask = {64{1'b1}} >> (64 - VALUE_WIDTH);
        v = value & mask;
        if (rdx < RADIX_MIN)
            base = 64'(RADIX_MIN);
        else if (rdx > RADIX_MAX)
            base = 64'(RADIX_MAX);
        else
            base = 64'(rdx);
        neg = sgn && base == 64'(DECIMAL) && v[VALUE_WIDTH-1];
        if (neg)
            v = (~v + 64'd1) & mask;
        cap = MAX_DIGITS;
        if (cap > RESULT_CAP - int'(neg))
            cap = RESULT_CAP - int'(neg);
        if (cap < 1)
            cap = 1;
        // Collect digits least significant first, emit most significant first
        do
        begin
            digit_stack.push_front(v % base);
            v = v / base;
        end
        while (v != 0 && digit_stack.size() < cap);
        total = digit_stack.size() + int'(neg);
        if (neg)
            expected_chars.push_back('{CH_MINUS, total == 1});
        for (k = 0; k < digit_stack.size(); k++)
        begin
            d = digit_stack[k];
            if (d < 64'(DECIMAL))
                ch = CH_ZERO + d[7:0];
            else
                ch = CH_LETTER_A + (d[7:0] - 8'(DECIMAL));
            expected_chars.push_back('{ch, k == digit_stack.size() - 1});
        end
    endfunction

    function automatic text_request_t make_request(input logic [63:0] v, input logic s,
                                                   input logic [RADIX_W-1:0] r,
                                                   input bit d = 1'b0);
        text_request_t req;
        req.number_bits = v;
        req.signed_mode = s;
        req.radix       = r;
        req.drain_first = d;
        return req;
    endfunction

    // Random value: full width, small, small negative or truncated
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 1000));
            2: v = -64'($urandom_range(1, 100000));
            default: v = v >> $urandom_range(1, 63);
        endcase
        return v;
    endfunction

    // Mostly legal radixes, decimal often, sometimes any 6-bit code
    function automatic logic [RADIX_W-1:0] random_radix();
        logic [RADIX_W-1:0] r;
        case ($urandom_range(0, 9))
            0, 1:    r = DECIMAL;
            2:       r = RADIX_W'($urandom_range(0, 63));
            default: r = RADIX_W'($urandom_range(2, 36));
        endcase
        return r;
    endfunction

    // Driver: present requests in bursts, hold each until taken
    always @(posedge clk)
    begin
        text_request_t req;
        bit            sent;
        if (rst_n)
        begin
            sent = in_valid && in_ready;
            if (sent)
                predict_text(number_bits, signed_mode, radix);
            if (in_valid && !sent)
            begin
                // hold the current request
            end
            else if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_requests.size() == 0)
                in_valid <= 1'b0;
            else if (pending_requests[0].drain_first && expected_chars.size() != 0)
                in_valid <= 1'b0;
            else
            begin
                req = pending_requests.pop_front();
                in_valid    <= 1'b1;
                number_bits <= req.number_bits;
                signed_mode <= req.signed_mode;
                radix       <= req.radix;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 8);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // Receiver: stall on a rotating pattern, renewed now and then
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_age == 31)
            begin
                stall_age     <= 0;
                stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            end
            else
            begin
                stall_age     <= stall_age + 1;
                stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
            end
            out_ready <= stall_pattern[0];
        end
    end

    // Monitor: compare each character with the oldest expectation
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("unexpected character: out_char %h last_char %b", out_char, last_char);
                fail_count++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (out_char !== want.out_char)
                begin
                    $error("out_char: expected %h, got %h", want.out_char, out_char);
                    fail_count++;
                end
                if (last_char !== want.last_char)
                begin
                    $error("last_char: expected %b, got %b", want.last_char, last_char);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int i;
        // Directed: zero, extremes, sign handling, radix saturation
        pending_requests.push_back(make_request(64'd0, 1'b0, DECIMAL));
        pending_requests.push_back(make_request(64'd0, 1'b1, DECIMAL));
        pending_requests.push_back(make_request({64{1'b1}}, 1'b0, DECIMAL));
        pending_requests.push_back(make_request({64{1'b1}}, 1'b1, DECIMAL));
        pending_requests.push_back(make_request(64'h8000_0000_0000_0000, 1'b1, DECIMAL));
        pending_requests.push_back(make_request(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, DECIMAL));
        pending_requests.push_back(make_request(-64'd12345, 1'b1, DECIMAL));
        pending_requests.push_back(make_request(64'd1, 1'b1, DECIMAL));
        pending_requests.push_back(make_request(64'd9, 1'b0, DECIMAL));
        pending_requests.push_back(make_request({64{1'b1}}, 1'b0, RADIX_MIN));
        pending_requests.push_back(make_request(64'd1, 1'b0, RADIX_MIN));
        pending_requests.push_back(make_request({64{1'b1}}, 1'b0, RADIX_MAX));
        pending_requests.push_back(make_request(64'd35, 1'b0, RADIX_MAX));
        pending_requests.push_back(make_request(64'd255, 1'b0, 6'd16));
        pending_requests.push_back(make_request({64{1'b1}}, 1'b1, 6'd16));
        pending_requests.push_back(make_request(64'h8000_0000_0000_0000, 1'b1, 6'd8));
        pending_requests.push_back(make_request(64'd10, 1'b0, 6'd11));
        pending_requests.push_back(make_request(64'd5, 1'b0, 6'd0));
        pending_requests.push_back(make_request(64'd6, 1'b1, 6'd1));
        pending_requests.push_back(make_request(64'd71, 1'b0, 6'd37));
        pending_requests.push_back(make_request({64{1'b1}}, 1'b0, 6'd63));
        pending_requests.push_back(make_request(64'h0123_4567_89AB_CDEF, 1'b0, 6'd3));
        // Random requests, draining the output now and then
        for (i = 0; i < RANDOM_REQUESTS; i++)
            pending_requests.push_back(make_request(random_value(), 1'($urandom),
                                                    random_radix(), i % DRAIN_EVERY == 0));
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // Wait for every request to be taken and every character to arrive
        while (pending_requests.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
hdl/itrt_pkg.sv
hdl/itrt_ram.sv
hdl/itrt_divider.sv
hdl/integer_to_radix_text_core.sv
hdl/itrt_checker.sv
bench/tb_top.sv
